// ===== rtl/bct_pkg.sv =====
// bct_pkg: types, constants and codes for the bundle custody table
// no dependencies
package bct_pkg;
	localparam int CUSTODY_SLOTS_DEF = 16;
	localparam int SEEN_DEPTH_DEF = 32;
	localparam int ID_BITS_DEF = 64;

	typedef enum logic [1:0] {
		CMD_ACCEPT = 2'd0,
		CMD_DELIVER = 2'd1,
		CMD_SWEEP = 2'd2,
		CMD_QUERY = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_UPGRADED = 3'd1,
		ST_CLASS = 3'd2,
		ST_EXPIRED = 3'd3,
		ST_EXHAUSTED = 3'd4,
		ST_DUPLICATE = 3'd5,
		ST_FULL = 3'd6
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SEEN_RD,
		S_SEEN_CHK,
		S_SLOT_RD,
		S_SLOT_CHK,
		S_WRITE,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_SWEEP_RD,
		S_SWEEP_CHK,
		S_SEENSH_RD,
		S_SEENSH_WR,
		S_SEEN_ADD,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [63:0] bundle_id;
		logic [7:0] hops_remaining;
		logic [7:0] fanout_remaining;
		logic [7:0] traffic_class;
		logic [31:0] expiry_time;
		logic [15:0] payload_handle;
		logic [31:0] current_time;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic is_held;
		logic [4:0] dropped_count;
		logic [4:0] occupancy;
	} rsp_t;

	// slot record below the id: hops, fanout, expiry, handle
	localparam int REC_BITS = 8 + 8 + 32 + 16;
endpackage

// ===== rtl/bct_if.sv =====
// bct_if: valid/ready channel carrying one payload of type T
// depends on bct_pkg for payload types
interface bct_if #(parameter type T = bct_pkg::req_t) (input logic clk);
	logic valid;
	logic ready;
	T data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/bct_ram.sv =====
// bct_ram: generic single-port-write, one-read synchronous ram
// registered read data, no dependencies
module bct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/bct_ctrl.sv =====
// bct_ctrl: sequencer that scans and edits the slot and seen memories
// depends on bct_pkg; drives two bct_ram instances in the top level
module bct_ctrl #(
	parameter int CUSTODY_SLOTS = bct_pkg::CUSTODY_SLOTS_DEF,
	parameter int SEEN_DEPTH = bct_pkg::SEEN_DEPTH_DEF,
	parameter int ID_BITS = bct_pkg::ID_BITS_DEF,
	localparam int SA = $clog2(CUSTODY_SLOTS > 1 ? CUSTODY_SLOTS : 2),
	localparam int NA = $clog2(SEEN_DEPTH > 1 ? SEEN_DEPTH : 2),
	localparam int SC = $clog2(CUSTODY_SLOTS + 1),
	localparam int NC = $clog2(SEEN_DEPTH + 1),
	localparam int SW = ID_BITS + bct_pkg::REC_BITS
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input bct_pkg::req_t in_data,
	output logic out_valid,
	input logic out_ready,
	output bct_pkg::rsp_t out_data,
	output logic slot_we,
	output logic [SA-1:0] slot_waddr,
	output logic [SW-1:0] slot_wdata,
	output logic [SA-1:0] slot_raddr,
	input logic [SW-1:0] slot_rdata,
	output logic seen_we,
	output logic [NA-1:0] seen_waddr,
	output logic [ID_BITS-1:0] seen_wdata,
	output logic [NA-1:0] seen_raddr,
	input logic [ID_BITS-1:0] seen_rdata
);
	bct_pkg::state_t state_q, state_d;
	bct_pkg::req_t req_q;
	logic [SC-1:0] used_q, used_d;
	logic [NC-1:0] seen_used_q, seen_used_d;
	logic [NA-1:0] head_q, head_d; // oldest seen entry once the list is full
	logic [SC-1:0] idx_q, idx_d;
	logic [SC-1:0] rd_q, rd_d; // read pointer for the sweep and the deliver shift
	logic [NC-1:0] nidx_q, nidx_d;
	logic [2:0] status_q, status_d;
	logic held_q, held_d;
	logic [SC-1:0] drop_q, drop_d;
	logic out_valid_q, out_valid_d;

	logic [ID_BITS-1:0] id;
	logic [SW-1:0] new_rec;
	logic [ID_BITS-1:0] rd_id;
	logic [7:0] rd_hops;
	logic [31:0] rd_exp;

	assign id = req_q.bundle_id[ID_BITS-1:0];
	assign new_rec = {id, req_q.hops_remaining, req_q.fanout_remaining,
		req_q.expiry_time, req_q.payload_handle};
	assign rd_id = slot_rdata[SW-1 -: ID_BITS];
	assign rd_hops = slot_rdata[63:56];
	assign rd_exp = slot_rdata[47:16];

	assign in_ready = (state_q == bct_pkg::S_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data.status = status_q;
	assign out_data.is_held = held_q;
	assign out_data.dropped_count = 5'(drop_q);
	assign out_data.occupancy = 5'(used_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bct_pkg::S_IDLE;
			used_q <= '0;
			seen_used_q <= '0;
			head_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			used_q <= used_d;
			seen_used_q <= seen_used_d;
			head_q <= head_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			req_q <= in_data;
		idx_q <= idx_d;
		rd_q <= rd_d;
		nidx_q <= nidx_d;
		status_q <= status_d;
		held_q <= held_d;
		drop_q <= drop_d;
	end

	always_comb begin
		state_d = state_q;
		used_d = used_q;
		seen_used_d = seen_used_q;
		head_d = head_q;
		idx_d = idx_q;
		rd_d = rd_q;
		nidx_d = nidx_q;
		status_d = status_q;
		held_d = held_q;
		drop_d = drop_q;
		out_valid_d = out_valid_q;
		slot_we = 1'b0;
		slot_waddr = idx_q[SA-1:0];
		slot_wdata = new_rec;
		slot_raddr = idx_q[SA-1:0];
		seen_we = 1'b0;
		seen_waddr = nidx_q[NA-1:0];
		seen_wdata = id;
		seen_raddr = nidx_q[NA-1:0];
		if (out_valid_q && out_ready)
			out_valid_d = 1'b0;
		case (state_q)
			bct_pkg::S_IDLE: begin
				if (in_valid && in_ready) begin
					idx_d = '0;
					rd_d = '0;
					nidx_d = '0;
					status_d = bct_pkg::ST_OK;
					held_d = 1'b0;
					drop_d = '0;
					case (bct_pkg::cmd_t'(in_data.cmd))
						bct_pkg::CMD_ACCEPT: begin
							if (in_data.traffic_class != 8'd1) begin
								status_d = bct_pkg::ST_CLASS;
								state_d = bct_pkg::S_DONE;
							end else if (in_data.expiry_time <= in_data.current_time) begin
								status_d = bct_pkg::ST_EXPIRED;
								state_d = bct_pkg::S_DONE;
							end else if (in_data.hops_remaining == 8'd0) begin
								status_d = bct_pkg::ST_EXHAUSTED;
								state_d = bct_pkg::S_DONE;
							end else
								state_d = bct_pkg::S_SEEN_RD;
						end
						bct_pkg::CMD_SWEEP: state_d = bct_pkg::S_SWEEP_RD;
						default: state_d = bct_pkg::S_SLOT_RD;
					endcase
				end
			end
			// seen list scan for accept
			bct_pkg::S_SEEN_RD: begin
				if (nidx_q >= seen_used_q)
					state_d = bct_pkg::S_SLOT_RD;
				else
					state_d = bct_pkg::S_SEEN_CHK;
			end
			bct_pkg::S_SEEN_CHK: begin
				if (seen_rdata == id) begin
					status_d = bct_pkg::ST_DUPLICATE;
					state_d = bct_pkg::S_DONE;
				end else begin
					nidx_d = nidx_q + 1'b1;
					state_d = bct_pkg::S_SEEN_RD;
				end
			end
			// slot scan for id match
			bct_pkg::S_SLOT_RD: begin
				if (idx_q >= used_q) begin
					case (bct_pkg::cmd_t'(req_q.cmd))
						bct_pkg::CMD_ACCEPT: begin
							if (used_q >= SC'(CUSTODY_SLOTS)) begin
								status_d = bct_pkg::ST_FULL;
								state_d = bct_pkg::S_DONE;
							end else
								state_d = bct_pkg::S_WRITE;
						end
						bct_pkg::CMD_DELIVER: begin
							status_d = bct_pkg::ST_DUPLICATE;
							state_d = bct_pkg::S_DONE;
						end
						default: state_d = bct_pkg::S_DONE;
					endcase
				end else
					state_d = bct_pkg::S_SLOT_CHK;
			end
			bct_pkg::S_SLOT_CHK: begin
				if (rd_id == id) begin
					case (bct_pkg::cmd_t'(req_q.cmd))
						bct_pkg::CMD_ACCEPT: begin
							if (req_q.hops_remaining > rd_hops) begin
								status_d = bct_pkg::ST_UPGRADED;
								state_d = bct_pkg::S_WRITE;
							end else begin
								status_d = bct_pkg::ST_DUPLICATE;
								state_d = bct_pkg::S_DONE;
							end
						end
						bct_pkg::CMD_DELIVER: begin
							rd_d = idx_q + 1'b1;
							state_d = bct_pkg::S_SHIFT_RD;
						end
						default: begin
							held_d = 1'b1;
							state_d = bct_pkg::S_DONE;
						end
					endcase
				end else begin
					idx_d = idx_q + 1'b1;
					state_d = bct_pkg::S_SLOT_RD;
				end
			end
			bct_pkg::S_WRITE: begin
				slot_we = 1'b1;
				if (status_q == bct_pkg::ST_OK)
					used_d = used_q + 1'b1;
				state_d = bct_pkg::S_DONE;
			end
			// close the gap: copy rd_q to idx_q
			bct_pkg::S_SHIFT_RD: begin
				slot_raddr = rd_q[SA-1:0];
				if (rd_q >= used_q) begin
					used_d = used_q - 1'b1;
					if (bct_pkg::cmd_t'(req_q.cmd) == bct_pkg::CMD_DELIVER) begin
						nidx_d = '0;
						state_d = bct_pkg::S_SEENSH_RD;
					end else
						state_d = bct_pkg::S_SWEEP_RD;
				end else
					state_d = bct_pkg::S_SHIFT_WR;
			end
			bct_pkg::S_SHIFT_WR: begin
				slot_we = 1'b1;
				slot_wdata = slot_rdata;
				idx_d = idx_q + 1'b1;
				rd_d = rd_q + 1'b1;
				state_d = bct_pkg::S_SHIFT_RD;
			end
			// sweep: rd_q scans, idx_q is the compacted write pointer
			bct_pkg::S_SWEEP_RD: begin
				slot_raddr = rd_q[SA-1:0];
				if (rd_q >= used_q) begin
					used_d = idx_q;
					state_d = bct_pkg::S_DONE;
				end else
					state_d = bct_pkg::S_SWEEP_CHK;
			end
			bct_pkg::S_SWEEP_CHK: begin
				if (rd_exp <= req_q.current_time)
					drop_d = drop_q + 1'b1;
				else begin
					slot_we = 1'b1;
					slot_wdata = slot_rdata;
					idx_d = idx_q + 1'b1;
				end
				rd_d = rd_q + 1'b1;
				state_d = bct_pkg::S_SWEEP_RD;
			end
			// deliver: seen membership check, then append or overwrite the oldest
			bct_pkg::S_SEENSH_RD: begin
				if (nidx_q >= seen_used_q)
					state_d = bct_pkg::S_SEEN_ADD;
				else
					state_d = bct_pkg::S_SEENSH_WR;
			end
			bct_pkg::S_SEENSH_WR: begin
				if (seen_rdata == id)
					state_d = bct_pkg::S_DONE;
				else begin
					nidx_d = nidx_q + 1'b1;
					state_d = bct_pkg::S_SEENSH_RD;
				end
			end
			// full list works as a ring: head_q holds the oldest entry
			bct_pkg::S_SEEN_ADD: begin
				if (seen_used_q >= NC'(SEEN_DEPTH)) begin
					seen_waddr = head_q;
					head_d = (head_q == NA'(SEEN_DEPTH - 1)) ? '0 : head_q + 1'b1;
				end else begin
					seen_waddr = seen_used_q[NA-1:0];
					seen_used_d = seen_used_q + 1'b1;
				end
				seen_we = 1'b1;
				state_d = bct_pkg::S_DONE;
			end
			bct_pkg::S_DONE: begin
				out_valid_d = 1'b1;
				state_d = bct_pkg::S_IDLE;
			end
			default: state_d = bct_pkg::S_IDLE;
		endcase
	end
endmodule

// ===== rtl/bundle_custody_table_unit.sv =====
// bundle_custody_table_unit: top level of the bundle custody table
// depends on bct_pkg, bct_if, bct_ram, bct_ctrl
// one transaction at a time: next input taken once the result has left
// transaction time set by the read-then-check scan steps over the slot and seen memories
// reset clears occupancy, seen count and oldest pointer; memory contents stay undefined
module bundle_custody_table_unit #(
	parameter int CUSTODY_SLOTS = bct_pkg::CUSTODY_SLOTS_DEF,
	parameter int SEEN_DEPTH = bct_pkg::SEEN_DEPTH_DEF,
	parameter int ID_BITS = bct_pkg::ID_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	bct_if.sink req,
	bct_if.source rsp
);
	localparam int SA = $clog2(CUSTODY_SLOTS > 1 ? CUSTODY_SLOTS : 2);
	localparam int NA = $clog2(SEEN_DEPTH > 1 ? SEEN_DEPTH : 2);
	localparam int SW = ID_BITS + bct_pkg::REC_BITS;

	logic slot_we, seen_we;
	logic [SA-1:0] slot_waddr, slot_raddr;
	logic [NA-1:0] seen_waddr, seen_raddr;
	logic [SW-1:0] slot_wdata, slot_rdata;
	logic [ID_BITS-1:0] seen_wdata, seen_rdata;

	bct_ctrl #(.CUSTODY_SLOTS(CUSTODY_SLOTS), .SEEN_DEPTH(SEEN_DEPTH),
		.ID_BITS(ID_BITS)) u_ctrl (
		.clk, .arst_n,
		.in_valid(req.valid), .in_ready(req.ready), .in_data(req.data),
		.out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.data),
		.slot_we, .slot_waddr, .slot_wdata, .slot_raddr, .slot_rdata,
		.seen_we, .seen_waddr, .seen_wdata, .seen_raddr, .seen_rdata
	);

	bct_ram #(.WIDTH(SW), .DEPTH(CUSTODY_SLOTS)) u_slots (
		.clk, .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
		.raddr(slot_raddr), .rdata(slot_rdata)
	);

	bct_ram #(.WIDTH(ID_BITS), .DEPTH(SEEN_DEPTH)) u_seen (
		.clk, .we(seen_we), .waddr(seen_waddr), .wdata(seen_wdata),
		.raddr(seen_raddr), .rdata(seen_rdata)
	);
endmodule

// ===== rtl/bct_checker.sv =====
// bct_checker: port-level assertions for the custody table
// depends on bct_pkg; bound to bundle_custody_table_unit
module bct_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input bct_pkg::rsp_t rsp_data
);
	a_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.occupancy <= 5'd16)
		else $error("occupancy out of range");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !req_ready)
		else $error("input taken while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result dropped");
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.dropped_count != 5'd0 |-> rsp_data.status == bct_pkg::ST_OK)
		else $error("sweep status");
	a_held: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.is_held |-> rsp_data.occupancy != 5'd0)
		else $error("held with empty table");
endmodule

bind bundle_custody_table_unit bct_checker u_bct_checker (
	.clk(clk), .arst_n(arst_n),
	.req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);

// ===== verif/tb_top.sv =====
// tb_top: self-checking testbench for bundle_custody_table_unit
// depends on bct_pkg, bct_if and the custody table rtl
`timescale 1ns / 1ps

module tb_top;
	localparam int SLOTS = bct_pkg::CUSTODY_SLOTS_DEF;
	localparam int SEEN = bct_pkg::SEEN_DEPTH_DEF;
	localparam int SETTLE = 4 * (SLOTS + SEEN) + 8;
	localparam longint LIMIT = 1500000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	bct_if #(.T(bct_pkg::req_t)) req (.clk(clk));
	bct_if #(.T(bct_pkg::rsp_t)) rsp (.clk(clk));

	bundle_custody_table_unit DUT (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	// custody model state
	logic [63:0] held_id [SLOTS];
	logic [7:0] held_hops [SLOTS];
	logic [31:0] held_exp [SLOTS];
	int held_cnt = 0;
	logic [63:0] seen_id [SEEN];
	int seen_cnt = 0;

	bct_pkg::req_t pending_q [$];
	bct_pkg::rsp_t awaited_q [$];
	logic [63:0] id_pool [$];
	int send_idle_pct = 33;
	int recv_idle_pct = 72;
	bit hold_off = 1'b0;
	bit req_fire = 1'b0;
	int errors = 0;
	longint cycles = 0;

	function automatic int slot_of(logic [63:0] id);
		for (int i = 0; i < held_cnt; i++)
			if (held_id[i] == id) return i;
		return -1;
	endfunction

	function automatic bit was_seen(logic [63:0] id);
		for (int i = 0; i < seen_cnt; i++)
			if (seen_id[i] == id) return 1'b1;
		return 1'b0;
	endfunction

	function automatic void drop_slot(int at);
		for (int i = at; i + 1 < held_cnt; i++) begin
			held_id[i] = held_id[i + 1];
			held_hops[i] = held_hops[i + 1];
			held_exp[i] = held_exp[i + 1];
		end
		held_cnt--;
	endfunction

	function automatic bct_pkg::rsp_t custody_outcome(bct_pkg::req_t r);
		bct_pkg::rsp_t o;
		int at;
		o = '0;
		o.status = bct_pkg::ST_OK;
		case (bct_pkg::cmd_t'(r.cmd))
			bct_pkg::CMD_ACCEPT: begin
				if (r.traffic_class != 8'd1) o.status = bct_pkg::ST_CLASS;
				else if (r.expiry_time <= r.current_time) o.status = bct_pkg::ST_EXPIRED;
				else if (r.hops_remaining == 8'd0) o.status = bct_pkg::ST_EXHAUSTED;
				else if (was_seen(r.bundle_id)) o.status = bct_pkg::ST_DUPLICATE;
				else begin
					at = slot_of(r.bundle_id);
					if (at >= 0) begin
						if (r.hops_remaining > held_hops[at]) begin
							held_hops[at] = r.hops_remaining;
							held_exp[at] = r.expiry_time;
							o.status = bct_pkg::ST_UPGRADED;
						end else o.status = bct_pkg::ST_DUPLICATE;
					end else if (held_cnt >= SLOTS) o.status = bct_pkg::ST_FULL;
					else begin
						held_id[held_cnt] = r.bundle_id;
						held_hops[held_cnt] = r.hops_remaining;
						held_exp[held_cnt] = r.expiry_time;
						held_cnt++;
					end
				end
			end
			bct_pkg::CMD_DELIVER: begin
				at = slot_of(r.bundle_id);
				if (at >= 0) begin
					drop_slot(at);
					if (!was_seen(r.bundle_id)) begin
						if (seen_cnt >= SEEN) begin
							for (int i = 0; i + 1 < SEEN; i++) seen_id[i] = seen_id[i + 1];
							seen_cnt = SEEN - 1;
						end
						seen_id[seen_cnt] = r.bundle_id;
						seen_cnt++;
					end
				end else o.status = bct_pkg::ST_DUPLICATE;
			end
			bct_pkg::CMD_SWEEP: begin
				int i;
				i = 0;
				while (i < held_cnt) begin
					if (held_exp[i] <= r.current_time) begin
						drop_slot(i);
						o.dropped_count++;
					end else i++;
				end
			end
			default: o.is_held = (slot_of(r.bundle_id) >= 0);
		endcase
		o.occupancy = held_cnt[4:0];
		return o;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	function automatic logic [63:0] pick_id();
		if (id_pool.size() > 0 && $urandom_range(0, 9) < 8)
			return id_pool[$urandom_range(0, id_pool.size() - 1)];
		return {$urandom, $urandom};
	endfunction

	function automatic bct_pkg::req_t make_item(bct_pkg::cmd_t c, logic [63:0] id,
			logic [7:0] hops, logic [7:0] cls, logic [31:0] exp, logic [31:0] now);
		bct_pkg::req_t r;
		r.cmd = c;
		r.bundle_id = id;
		r.hops_remaining = hops;
		r.fanout_remaining = 8'($urandom);
		r.traffic_class = cls;
		r.expiry_time = exp;
		r.payload_handle = 16'($urandom);
		r.current_time = now;
		return r;
	endfunction

	function automatic bct_pkg::req_t random_item();
		int k;
		logic [31:0] now;
		k = $urandom_range(0, 99);
		now = 32'($urandom_range(1000, 2000));
		if (k < 45)
			return make_item(bct_pkg::CMD_ACCEPT, pick_id(),
				($urandom_range(0, 19) == 0) ? 8'd0 : 8'($urandom),
				($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'd1,
				($urandom_range(0, 9) == 0) ? 32'($urandom)
					: now + 32'($urandom_range(1, 3000)),
				now);
		if (k < 75) return make_item(bct_pkg::CMD_DELIVER, pick_id(), 8'($urandom),
			8'($urandom), 32'($urandom), now);
		if (k < 85) return make_item(bct_pkg::CMD_SWEEP, pick_id(), 8'($urandom),
			8'($urandom), 32'($urandom),
			($urandom_range(0, 29) == 0) ? 32'($urandom) : now + 32'($urandom_range(0, 800)));
		return make_item(bct_pkg::CMD_QUERY, pick_id(), 8'($urandom), 8'($urandom),
			32'($urandom), 32'($urandom));
	endfunction

	task automatic wait_drained();
		while (pending_q.size() > 0 || awaited_q.size() > 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		forever #4 clk = ~clk;
	end

	// driver: a new transaction only after the previous one was taken
	always @(negedge clk) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.data <= '0;
		end else if (!req.valid || req_fire) begin
			if (pending_q.size() > 0 && !hold_off
					&& $urandom_range(0, 99) >= send_idle_pct) begin
				req.valid <= 1'b1;
				req.data <= pending_q.pop_front();
			end else req.valid <= 1'b0;
		end
	end

	// predictor runs when a transaction is accepted on the request side
	always @(posedge clk) begin
		req_fire <= arst_n && req.valid && req.ready;
		if (arst_n && req.valid && req.ready)
			awaited_q.push_back(custody_outcome(req.data));
	end

	// monitor
	always @(negedge clk) rsp.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	always @(posedge clk) begin
		bct_pkg::rsp_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (awaited_q.size() == 0) report_mismatch("unexpected transaction", 1, 0);
			else begin
				want = awaited_q.pop_front();
				if (rsp.data.status !== want.status)
					report_mismatch("status", int'(rsp.data.status), int'(want.status));
				if (rsp.data.is_held !== want.is_held)
					report_mismatch("is_held", int'(rsp.data.is_held), int'(want.is_held));
				if (rsp.data.dropped_count !== want.dropped_count)
					report_mismatch("dropped_count", int'(rsp.data.dropped_count),
						int'(want.dropped_count));
				if (rsp.data.occupancy !== want.occupancy)
					report_mismatch("occupancy", int'(rsp.data.occupancy),
						int'(want.occupancy));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	initial begin
		logic [63:0] ids [4];
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		ids[0] = 64'hFFFF_FFFF_FFFF_FFFF;
		ids[1] = 64'd0;
		ids[2] = 64'h8000_0000_0000_0001;
		ids[3] = 64'h5555_AAAA_5555_AAAA;
		// directed: checks in order, upgrade, full, deliver, seen, sweep, query
		pending_q.push_back(make_item(bct_pkg::CMD_ACCEPT, ids[0], 8'hFF, 8'd0,
			32'hFFFF_FFFF, 32'd0));
		pending_q.push_back(make_item(bct_pkg::CMD_ACCEPT, ids[0], 8'hFF, 8'hFF,
			32'hFFFF_FFFF, 32'd0));
		pending_q.push_back(make_item(bct_pkg::CMD_ACCEPT, ids[0], 8'hFF, 8'd1,
			32'd5, 32'd5));
		pending_q.push_back(make_item(bct_pkg::CMD_ACCEPT, ids[0], 8'd0, 8'd1,
			32'hFFFF_FFFF, 32'd0));
		pending_q.push_back(make_item(bct_pkg::CMD_ACCEPT, ids[0], 8'd3, 8'd1,
			32'hFFFF_FFFF, 32'd0));
		pending_q.push_back(make_item(bct_pkg::CMD_ACCEPT, ids[0], 8'd2, 8'd1,
			32'd100, 32'd0));
		pending_q.push_back(make_item(bct_pkg::CMD_ACCEPT, ids[0], 8'hFF, 8'd1,
			32'd50, 32'd0));
		for (int i = 1; i < 17; i++)
			pending_q.push_back(make_item(bct_pkg::CMD_ACCEPT, (i < 4) ? ids[i] : 64'(i),
				8'd1, 8'd1, 32'd10 + 32'(i), 32'd0));
		pending_q.push_back(make_item(bct_pkg::CMD_QUERY, ids[1], 8'd0, 8'd0, 32'd0, 32'd0));
		pending_q.push_back(make_item(bct_pkg::CMD_DELIVER, ids[0], 8'd0, 8'd0, 32'd0, 32'd0));
		pending_q.push_back(make_item(bct_pkg::CMD_DELIVER, ids[0], 8'd0, 8'd0, 32'd0, 32'd0));
		pending_q.push_back(make_item(bct_pkg::CMD_ACCEPT, ids[0], 8'd9, 8'd1, 32'd99, 32'd0));
		pending_q.push_back(make_item(bct_pkg::CMD_SWEEP, 64'd0, 8'd0, 8'd0, 32'd0, 32'd20));
		pending_q.push_back(make_item(bct_pkg::CMD_SWEEP, 64'd0, 8'd0, 8'd0, 32'd0,
			32'hFFFF_FFFF));
		pending_q.push_back(make_item(bct_pkg::CMD_QUERY, ids[2], 8'd0, 8'd0, 32'd0, 32'd0));
		for (int i = 0; i < 48; i++) id_pool.push_back({$urandom, $urandom});
		for (int i = 0; i < 4; i++) id_pool.push_back(ids[i]);
		for (int ph = 0; ph < 3; ph++) begin
			if (ph > 0) begin
				while (pending_q.size() > 0 || req.valid) @(posedge clk);
			end
			if (ph == 1) begin
				send_idle_pct = 72;
				recv_idle_pct = 33;
			end else if (ph == 2) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			for (int n = 0; n < 340; n++) begin
				pending_q.push_back(random_item());
				if (n == 170) begin
					while (pending_q.size() > 0) @(posedge clk);
					hold_off = 1'b1;
					while (awaited_q.size() > 0 || req.valid) @(posedge clk);
					repeat (SETTLE) @(posedge clk);
					hold_off = 1'b0;
				end
			end
			// new id generation keeps the seen list rolling over
			for (int i = 0; i < 16; i++) id_pool[$urandom_range(0, id_pool.size() - 1)] =
				{$urandom, $urandom};
		end
		while (pending_q.size() > 0 || req.valid) @(posedge clk);
		wait_drained();
		if (errors == 0) $display("tb_top: PASS");
		else $display("tb_top: FAIL");
		$finish;
	end
endmodule

// ===== filelist.f =====
rtl/bct_pkg.sv
rtl/bct_if.sv
rtl/bct_ram.sv
rtl/bct_ctrl.sv
rtl/bundle_custody_table_unit.sv
rtl/bct_checker.sv
verif/tb_top.sv
